// ===== rtl/core/bmfgl_pkg.sv =====
// Package for the bitmap font glyph layout block: field widths, codes and
// the item structs shared by the front end, the queue and the back end.
`default_nettype none
package bmfgl_pkg;
   localparam int TableEntries = 128;
   localparam int IdxW = $clog2(TableEntries);
   localparam int EntryW = 62;
   localparam logic [7:0] NewlineCode = 8'd10;
   localparam logic [14:0] PosMax = 15'h7fff;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_PLACE  = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_NEWLINE = 2'd0,
      OP_GLYPH   = 2'd1,
      OP_FINISH  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_LINE_HEIGHT  = 2'd0,
      REG_ATLAS_WIDTH  = 2'd1,
      REG_ATLAS_HEIGHT = 2'd2,
      REG_NONE         = 2'd3
   } reg_type;

   typedef struct packed {
      logic [10:0] ax;
      logic [10:0] ay;
      logic [7:0]  w;
      logic [7:0]  h;
      logic [7:0]  ox;
      logic [7:0]  oy;
      logic [7:0]  adv;
   } entry_type;

   // one classified item headed for the back end
   typedef struct packed {
      op_type    op;
      entry_type entry;
   } job_type;

   typedef struct packed {
      logic         kind;
      logic [16:0]  u_left;
      logic [16:0]  u_right;
      logic [16:0]  v_top;
      logic [16:0]  v_bottom;
      logic [15:0]  screen_x;
      logic [15:0]  screen_y;
      logic [7:0]   quad_width;
      logic [7:0]   quad_height;
      logic [14:0]  extent_x;
      logic [14:0]  extent_y;
      logic [15:0]  glyph_count;
   } result_type;

   localparam int ResultW = $bits(result_type);
   localparam int ReqDataW = 8 * ((2 + 8 + 11 + 11 + 8 * 5 + 7) / 8);
   localparam int RspDataW = 8 * ((ResultW + 7) / 8);
endpackage
`default_nettype wire

// ===== rtl/core/bitmap_font_glyph_layout.sv =====
// Top level of the bitmap font glyph layout block: CSR port and the
// front / queue / back chain. Uses bmfgl_pkg and the bmfgl_* modules.
//  channel  | dir | beat
//  req_*    | in  | write / place / finish item
//  rsp_*    | out | glyph placement or text summary
//  csr_*    | in  | line pitch, atlas width, atlas height
// A glyph holds the back end while it takes the job, runs 29 steps of the
// bit-serial coordinate dividers and registers the result. Newline and
// finish jobs hold the back end only while it takes them; a finish job's
// summary is registered as the job is taken.
// Table writes finish in the front at the accepting edge.
// Synchronous reset clears cursor, totals and table valid bits.
// A held result stalls the back end; the queue lets the front keep taking until it is full.
`default_nettype none
module bitmap_font_glyph_layout
   import bmfgl_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // func, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
   // offset_x, offset_y, advance_x (low bit up)
   input  wire logic [ReqDataW-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // u_left, u_right, v_top, v_bottom, screen_x, screen_y, quad_width,
   // quad_height, widest x, text extent y, glyph_count (low bit up)
   output logic [RspDataW-1:0]      rsp_tdata,
   output logic                     rsp_tuser, // kind
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [3:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   logic [9:0]  row_pitch_ff;
   logic [12:0] atlas_width_ff, atlas_height_ff;
   reg_type     csr_reg;
   entry_type   wr_entry;
   logic        fj_valid, fj_ready, bj_valid, bj_ready;
   job_type     fj, bj;
   result_type  res;

   assign csr_pready = 1'b1;
   assign csr_reg = (csr_paddr[1:0] == 2'b00) ? reg_type'(csr_paddr[3:2]) : REG_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pitch_ff <= 10'd16;
         atlas_width_ff <= 13'd256;
         atlas_height_ff <= 13'd256;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_reg)
            REG_LINE_HEIGHT:  row_pitch_ff <= csr_pwdata[9:0];
            REG_ATLAS_WIDTH:  atlas_width_ff <= csr_pwdata[12:0];
            REG_ATLAS_HEIGHT: atlas_height_ff <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_LINE_HEIGHT:  csr_prdata = {22'd0, row_pitch_ff};
         REG_ATLAS_WIDTH:  csr_prdata = {19'd0, atlas_width_ff};
         REG_ATLAS_HEIGHT: csr_prdata = {19'd0, atlas_height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign wr_entry.ax  = req_tdata[20:10];
   assign wr_entry.ay  = req_tdata[31:21];
   assign wr_entry.w   = req_tdata[39:32];
   assign wr_entry.h   = req_tdata[47:40];
   assign wr_entry.ox  = req_tdata[55:48];
   assign wr_entry.oy  = req_tdata[63:56];
   assign wr_entry.adv = req_tdata[71:64];

   bmfgl_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .func(req_tdata[1:0]), .char_code(req_tdata[9:2]), .wr_entry,
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));

   bmfgl_queue u_queue (.clock, .reset, .push_valid(fj_valid), .push_ready(fj_ready),
      .push_job(fj), .pop_valid(bj_valid), .pop_ready(bj_ready), .pop_job(bj));

   bmfgl_back u_back (.clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready),
      .job(bj), .row_pitch(row_pitch_ff), .atlas_width(atlas_width_ff),
      .atlas_height(atlas_height_ff), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_res(res));

   assign rsp_tuser = res.kind;
   assign rsp_tdata = RspDataW'({res.glyph_count, res.extent_y, res.extent_x,
      res.quad_height, res.quad_width, res.screen_y, res.screen_x,
      res.v_bottom, res.v_top, res.u_right, res.u_left});
endmodule
`default_nettype wire

// ===== rtl/core/bmfgl_front.sv =====
// Front end: accepts request beats, writes the metrics table and reads the
// entry for a character; place and finish beats push a classified job. Uses bmfgl_pkg.
`default_nettype none
module bmfgl_front
   import bmfgl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [1:0]  func,
   input  wire logic [7:0]  char_code,
   input  wire entry_type   wr_entry,
   output logic             job_valid,
   input  wire logic        job_ready,
   output job_type          job
);
   entry_type table_mem [TableEntries];
   entry_type rd_data_ff;
   logic      valid_ff, valid_in;
   op_type    op_ff;
   logic      take, in_table, is_place;
   logic      rd_valid_ff;
   logic [TableEntries-1:0] vbits_ff, vbits_in;

   // one stage of buffering: accept when empty or leaving
   assign in_ready = !valid_ff || job_ready;
   assign take = in_valid && in_ready;
   assign in_table = ({1'b0, char_code} < 9'(TableEntries));
   assign is_place = (func == FUNC_PLACE) &&
      (char_code == NewlineCode || in_table);

   always_comb begin
      vbits_in = vbits_ff;
      if (take && func == FUNC_WRITE && in_table) begin
         vbits_in[char_code[IdxW-1:0]] = 1'b1;
      end
      valid_in = valid_ff && !job_ready;
      if (take && (is_place || func == FUNC_FINISH)) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && func == FUNC_WRITE && in_table) begin
         table_mem[char_code[IdxW-1:0]] <= wr_entry;
      end
      if (take) begin
         rd_data_ff <= table_mem[char_code[IdxW-1:0]];
         if (func == FUNC_FINISH) begin
            op_ff <= OP_FINISH;
         end else if (char_code == NewlineCode) begin
            op_ff <= OP_NEWLINE;
         end else begin
            op_ff <= OP_GLYPH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         vbits_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         vbits_ff <= vbits_in;
         if (take) begin
            rd_valid_ff <= in_table && vbits_ff[char_code[IdxW-1:0]];
         end
      end
   end

   assign job_valid = valid_ff;
   assign job.op = op_ff;
   assign job.entry = rd_valid_ff ? rd_data_ff : '0;
endmodule
`default_nettype wire

// ===== rtl/core/bmfgl_queue.sv =====
// Two-entry queue between front and back end. Uses bmfgl_pkg.
`default_nettype none
module bmfgl_queue
   import bmfgl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire job_type push_job,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output job_type      pop_job
);
   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_job = slot_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   property no_overflow;
      @(posedge clock) disable iff (reset) count_ff == 2'd2 |-> !push;
   endproperty
   assert property (no_overflow) else $error("queue overflow");
   property count_bound;
      @(posedge clock) disable iff (reset) count_ff != 2'd3;
   endproperty
   assert property (count_bound) else $error("queue count out of range");
   property pop_has_data;
      @(posedge clock) disable iff (reset) pop |-> count_ff != 2'd0;
   endproperty
   assert property (pop_has_data) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== rtl/core/bmfgl_divider.sv =====
// Restoring divider: 29-bit numerator over 13-bit divisor, one quotient bit
// per cycle, result saturated at 1.0. Uses bmfgl_pkg.
`default_nettype none
module bmfgl_divider
   import bmfgl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [11:0] numer,
   input  wire logic [12:0] denom,
   output logic             done,
   output logic [16:0]      quot
);
   logic [28:0] num_ff;
   logic [13:0] rem_ff;
   logic [28:0] q_ff;
   logic [12:0] den_ff;
   logic [4:0]  step_ff;
   logic        busy_ff;
   logic [13:0] trial;
   logic [14:0] diff;

   assign trial = {rem_ff[12:0], num_ff[28]};
   assign diff = {1'b0, trial} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done <= 1'b0;
      end else begin
         done <= !start && busy_ff && step_ff == 5'd28;
         if (start) begin
            busy_ff <= 1'b1;
            num_ff <= {1'b0, numer, 16'h0000};
            den_ff <= (denom == 13'd0) ? 13'd1 : denom;
            rem_ff <= '0;
            q_ff <= '0;
            step_ff <= 5'd0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[27:0], 1'b0};
            if (!diff[14]) begin
               rem_ff <= diff[13:0];
               q_ff <= {q_ff[27:0], 1'b1};
            end else begin
               rem_ff <= trial;
               q_ff <= {q_ff[27:0], 1'b0};
            end
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'd28) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign quot = (q_ff > 29'd65536) ? 17'd65536 : q_ff[16:0];
endmodule
`default_nettype wire

// ===== rtl/core/bmfgl_back.sv =====
// Back end: cursor and totals, four coordinate divisions, output register.
// Uses bmfgl_pkg and bmfgl_divider.
`default_nettype none
module bmfgl_back
   import bmfgl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_ready,
   input  wire job_type     job,
   input  wire logic [9:0]  row_pitch,
   input  wire logic [12:0] atlas_width,
   input  wire logic [12:0] atlas_height,
   output logic             out_valid,
   input  wire logic        out_ready,
   output result_type       out_res
);
   typedef enum logic [1:0] { ST_IDLE, ST_DIV } state_type;
   state_type  state_ff;
   logic [14:0] cx_ff, cy_ff, widest_ff, height_ff;
   logic [15:0] count_ff;
   result_type res_ff, sum_res, glyph_res;
   entry_type  ent_ff;
   logic       start, emit;
   logic [3:0] done;
   logic [16:0] q [4];
   logic [15:0] sx, sy;
   logic [14:0] cx_next;

   // dividers load at the accepting edge, so take the entry straight from the job
   bmfgl_divider u_div0 (.clock, .reset, .start, .numer({1'b0, job.entry.ax}),
      .denom(atlas_width), .done(done[0]), .quot(q[0]));
   bmfgl_divider u_div1 (.clock, .reset, .start,
      .numer(12'(job.entry.ax) + 12'(job.entry.w)),
      .denom(atlas_width), .done(done[1]), .quot(q[1]));
   bmfgl_divider u_div2 (.clock, .reset, .start, .numer({1'b0, job.entry.ay}),
      .denom(atlas_height), .done(done[2]), .quot(q[2]));
   bmfgl_divider u_div3 (.clock, .reset, .start,
      .numer(12'(job.entry.ay) + 12'(job.entry.h)),
      .denom(atlas_height), .done(done[3]), .quot(q[3]));

   function automatic logic [14:0] sat_add(logic [14:0] a, logic [9:0] b);
      logic [15:0] s;
      s = {1'b0, a} + 16'(b);
      return s[15] ? PosMax : s[14:0];
   endfunction

   function automatic logic [15:0] spos(logic [14:0] c, logic [7:0] o);
      logic [16:0] s;
      s = {2'b00, c} + {{9{o[7]}}, o};
      // cursor is never negative, so only the top can clip
      return (!s[16] && s[15]) ? 16'h7fff : s[15:0];
   endfunction

   assign job_ready = state_ff == ST_IDLE && (!out_valid || out_ready);
   assign start = state_ff == ST_IDLE && job_valid && job_ready &&
      job.op == OP_GLYPH;
   assign emit = (state_ff == ST_IDLE && job_valid && job_ready && job.op == OP_FINISH) ||
      (state_ff == ST_DIV && done[0]);
   assign cx_next = sat_add(cx_ff, {2'b00, ent_ff.adv});
   assign sx = spos(cx_ff, ent_ff.ox);
   assign sy = spos(cy_ff, ent_ff.oy);

   always_comb begin
      sum_res = '0;
      sum_res.kind = 1'b1;
      sum_res.extent_x = widest_ff;
      sum_res.extent_y = height_ff;
      sum_res.glyph_count = count_ff;
      glyph_res = '0;
      glyph_res.u_left = q[0];
      glyph_res.u_right = q[1];
      glyph_res.v_top = q[2];
      glyph_res.v_bottom = q[3];
      glyph_res.screen_x = sx;
      glyph_res.screen_y = sy;
      glyph_res.quad_width = ent_ff.w;
      glyph_res.quad_height = ent_ff.h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid <= 1'b0;
         cx_ff <= '0;
         cy_ff <= '0;
         widest_ff <= '0;
         height_ff <= '0;
         count_ff <= '0;
      end else begin
         if (emit) out_valid <= 1'b1;
         else if (out_ready) out_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid && job_ready) begin
                  ent_ff <= job.entry;
                  unique case (job.op)
                     OP_NEWLINE: begin
                        cy_ff <= sat_add(cy_ff, row_pitch);
                        cx_ff <= '0;
                     end
                     OP_FINISH: begin
                        res_ff <= sum_res;
                        cx_ff <= '0;
                        cy_ff <= '0;
                        widest_ff <= '0;
                        height_ff <= '0;
                        count_ff <= '0;
                     end
                     default: state_ff <= ST_DIV;
                  endcase
               end
            end
            ST_DIV: begin
               if (done[0]) begin
                  res_ff <= glyph_res;
                  if (count_ff != 16'hffff) count_ff <= count_ff + 16'd1;
                  cx_ff <= cx_next;
                  if (cx_next > widest_ff) widest_ff <= cx_next;
                  height_ff <= sat_add(cy_ff, row_pitch);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_res = res_ff;

   property divs_agree;
      @(posedge clock) disable iff (reset) done[0] |-> done == 4'hf;
   endproperty
   assert property (divs_agree) else $error("dividers out of step");
   property no_overwrite;
      @(posedge clock) disable iff (reset)
         out_valid && !out_ready |=> out_valid && $stable(res_ff);
   endproperty
   assert property (no_overwrite) else $error("pending result lost");
   property widest_bound;
      @(posedge clock) disable iff (reset) state_ff == ST_IDLE |-> widest_ff >= cx_ff;
   endproperty
   assert property (widest_bound) else $error("widest below cursor");
endmodule
`default_nettype wire
